// ----- hdl/rcf_pkg.sv -----
package rcf_pkg;

   // Widths of the argument counter and of the length accumulator.
   localparam int COUNT_BITS  = 16;
   localparam int LENGTH_BITS = 30;

   // Fixed widths of the item fields and of the register port.
   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int ARG_INDEX_W = 16;
   localparam int ERROR_W     = 2;
   localparam int MAX_ARGS_W  = 16;
   localparam int MAX_BULK_W  = 30;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 30;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ARGS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BULK_LEN = 2'd1;

   // Register reset values.
   localparam logic [MAX_ARGS_W-1:0] MAX_ARGS_RESET     = 16'd1024;
   localparam logic [MAX_BULK_W-1:0] MAX_BULK_LEN_RESET = 30'd536870912;

   // Protocol characters.
   localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

   // Number of bytes that follow the bulk data.
   localparam logic [LENGTH_BITS-1:0] TRAIL_BYTES = LENGTH_BITS'(2);

   // Result kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_DATA    = 2'd0,
      KIND_ARG_END = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   // Error codes.
   typedef enum logic [ERROR_W-1:0] {
      ERR_NONE      = 2'd0,
      ERR_BAD_CHAR  = 2'd1,
      ERR_BAD_COUNT = 2'd2,
      ERR_TOO_LONG  = 2'd3
   } error_type;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_CNT_NUM = 3'd1,
      PH_CNT_LF  = 3'd2,
      PH_DOLLAR  = 3'd3,
      PH_LEN_NUM = 3'd4,
      PH_LEN_LF  = 3'd5,
      PH_DATA    = 3'd6,
      PH_TRAIL   = 3'd7
   } phase_type;

endpackage

// ----- hdl/resp_command_framer_core.sv -----
// Each accepted byte is held in the input register, and the parser step then writes any result
// into the result register, where it is presented; a stall from the far side can hold both.
// Throughput: one byte per cycle unless the far side stalls; the single parser step sets it.
// Reset (synchronous, active high) returns the parser to idle, clears the counters and
// restores max_args to 1024 and max_bulk_len to 536870912.
module resp_command_framer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rcf_pkg::BYTE_W-1:0]        req_byte_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rcf_pkg::KIND_W-1:0]        rsp_result_kind,
   output logic [rcf_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic [rcf_pkg::ARG_INDEX_W-1:0]   rsp_arg_index,
   output logic                              rsp_command_done,
   output logic [rcf_pkg::ERROR_W-1:0]       rsp_error_code,
   input  logic                              csr_write,
   input  logic [rcf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rcf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rcf_pkg::*;

   localparam logic [32:0] CNT_LIMIT = (33'd1 << COUNT_BITS) - 33'd1;
   localparam logic [LENGTH_BITS-1:0] LEN_MASK = '1;
   localparam int PROD_W = LENGTH_BITS + 4;

   // Configuration registers.
   logic [MAX_ARGS_W-1:0] max_args_ff;
   logic [MAX_BULK_W-1:0] max_bulk_len_ff;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // Parser state.
   phase_type              phase_ff, phase_in;
   logic [COUNT_BITS-1:0]  args_expected_ff, args_expected_in;
   logic [COUNT_BITS-1:0]  args_seen_ff, args_seen_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [LENGTH_BITS-1:0] number_ff, number_in;
   logic                   saw_digit_ff, saw_digit_in;

   // Result register.
   logic                   out_valid_ff, out_valid_in;
   kind_type               out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0]      out_byte_ff, out_byte_in;
   logic [ARG_INDEX_W-1:0] out_index_ff, out_index_in;
   logic                   out_done_ff, out_done_in;
   error_type              out_error_ff, out_error_in;

   // Step helpers.
   logic                   step_en;
   logic                   emit;
   logic                   is_digit;
   logic [PROD_W-1:0]      digit_sum;
   logic [LENGTH_BITS-1:0] number_next;
   logic [32:0]            number_wide;
   logic [LENGTH_BITS-1:0] bytes_dec;
   logic [COUNT_BITS-1:0]  seen_inc;

   // The step runs when an item is held and the result register is free or being drained.
   assign step_en   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step_en;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff     <= MAX_ARGS_RESET;
         max_bulk_len_ff <= MAX_BULK_LEN_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_MAX_ARGS) begin
            max_args_ff <= csr_wdata[MAX_ARGS_W-1:0];
         end
         if (csr_index == CSR_MAX_BULK_LEN) begin
            max_bulk_len_ff <= csr_wdata[MAX_BULK_W-1:0];
         end
      end
   end

   // Input register: refilled whenever the held item moves on or the slot is empty.
   always_comb begin
      in_valid_in = in_valid_ff && !step_en;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_value;
      end
   end

   // Decimal accumulation, saturating at all ones: n * 10 + digit.
   assign is_digit    = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign digit_sum   = (PROD_W'(number_ff) << 3) + (PROD_W'(number_ff) << 1)
                        + PROD_W'(in_byte_ff - CHAR_ZERO);
   assign number_next = (digit_sum > PROD_W'(LEN_MASK)) ? LEN_MASK
                                                        : digit_sum[LENGTH_BITS-1:0];
   assign number_wide = 33'(number_ff);
   assign bytes_dec   = bytes_left_ff - LENGTH_BITS'(1);
   assign seen_inc    = args_seen_ff + COUNT_BITS'(1);

   // Parser state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         args_expected_ff <= '0;
         args_seen_ff     <= '0;
         bytes_left_ff    <= '0;
         number_ff        <= '0;
         saw_digit_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         args_expected_ff <= args_expected_in;
         args_seen_ff     <= args_seen_in;
         bytes_left_ff    <= bytes_left_in;
         number_ff        <= number_in;
         saw_digit_ff     <= saw_digit_in;
      end
   end

   // Next state and result for the held byte.
   always_comb begin
      phase_in         = phase_ff;
      args_expected_in = args_expected_ff;
      args_seen_in     = args_seen_ff;
      bytes_left_in    = bytes_left_ff;
      number_in        = number_ff;
      saw_digit_in     = saw_digit_ff;
      emit             = 1'b0;
      out_kind_in      = KIND_ERROR;
      out_byte_in      = '0;
      out_index_in     = '0;
      out_done_in      = 1'b0;
      out_error_in     = ERR_NONE;

      case (phase_ff)
         PH_IDLE: begin
            if (in_byte_ff == CHAR_STAR) begin
               number_in    = '0;
               saw_digit_in = 1'b0;
               phase_in     = PH_CNT_NUM;
            end
         end
         PH_CNT_NUM, PH_LEN_NUM: begin
            if (is_digit) begin
               number_in    = number_next;
               saw_digit_in = 1'b1;
            end else if (in_byte_ff == CHAR_CR) begin
               phase_in = (phase_ff == PH_CNT_NUM) ? PH_CNT_LF : PH_LEN_LF;
            end else begin
               emit         = 1'b1;
               out_error_in = ERR_BAD_CHAR;
               phase_in     = PH_IDLE;
            end
         end
         PH_CNT_LF: begin
            if (in_byte_ff != CHAR_LF || !saw_digit_ff) begin
               emit         = 1'b1;
               out_error_in = ERR_BAD_CHAR;
               phase_in     = PH_IDLE;
            end else if (number_ff == '0 || number_wide > CNT_LIMIT
                         || number_wide > 33'(max_args_ff)) begin
               emit         = 1'b1;
               out_error_in = ERR_BAD_COUNT;
               phase_in     = PH_IDLE;
            end else begin
               args_expected_in = COUNT_BITS'(number_ff);
               args_seen_in     = '0;
               phase_in         = PH_DOLLAR;
            end
         end
         PH_DOLLAR: begin
            if (in_byte_ff != CHAR_DOLLAR) begin
               emit         = 1'b1;
               out_error_in = ERR_BAD_CHAR;
               phase_in     = PH_IDLE;
            end else begin
               number_in    = '0;
               saw_digit_in = 1'b0;
               phase_in     = PH_LEN_NUM;
            end
         end
         PH_LEN_LF: begin
            if (in_byte_ff != CHAR_LF || !saw_digit_ff) begin
               emit         = 1'b1;
               out_error_in = ERR_BAD_CHAR;
               phase_in     = PH_IDLE;
            end else if (number_ff == LEN_MASK
                         || number_wide > 33'(max_bulk_len_ff)) begin
               emit         = 1'b1;
               out_error_in = ERR_TOO_LONG;
               phase_in     = PH_IDLE;
            end else if (number_ff == '0) begin
               // An empty bulk string goes straight to its trailer.
               bytes_left_in = TRAIL_BYTES;
               phase_in      = PH_TRAIL;
            end else begin
               bytes_left_in = number_ff;
               phase_in      = PH_DATA;
            end
         end
         PH_DATA: begin
            emit          = 1'b1;
            out_kind_in   = KIND_DATA;
            out_byte_in   = in_byte_ff;
            out_index_in  = ARG_INDEX_W'(args_seen_ff);
            bytes_left_in = bytes_dec;
            if (bytes_dec == '0) begin
               bytes_left_in = TRAIL_BYTES;
               phase_in      = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            bytes_left_in = bytes_dec;
            // The argument ends on the second trailing byte.
            if (bytes_dec == '0) begin
               emit         = 1'b1;
               out_kind_in  = KIND_ARG_END;
               out_index_in = ARG_INDEX_W'(args_seen_ff);
               out_done_in  = (seen_inc == args_expected_ff);
               args_seen_in = seen_inc;
               phase_in     = (seen_inc == args_expected_ff) ? PH_IDLE : PH_DOLLAR;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Result register: loaded by a step that emits, held while the far side stalls.
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (step_en) begin
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && emit) begin
         out_kind_ff  <= out_kind_in;
         out_byte_ff  <= out_byte_in;
         out_index_ff <= out_index_in;
         out_done_ff  <= out_done_in;
         out_error_ff <= out_error_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_data_byte    = out_byte_ff;
   assign rsp_arg_index    = out_index_ff;
   assign rsp_command_done = out_done_ff;
   assign rsp_error_code   = out_error_ff;

   // A stall towards the sender is only raised while an item is held.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> in_valid_ff)
      else $error("input stalled with no item held");

   // Every reported error returns the parser to idle.
   assert property (@(posedge clock) disable iff (reset)
      (step_en && emit && out_kind_in == KIND_ERROR) |=> phase_ff == PH_IDLE)
      else $error("parser not idle after an error");

   // Inside bulk data there is always at least one byte left.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_left_ff != '0)
      else $error("data phase with no bytes left");

   // The trailer counts down from two.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TRAIL |-> (bytes_left_ff == LENGTH_BITS'(1)
                                || bytes_left_ff == TRAIL_BYTES))
      else $error("trailer count out of range");

   // Command completion is only flagged on an argument end.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_done_ff) |-> out_kind_ff == KIND_ARG_END)
      else $error("command done on a result that is not an argument end");

endmodule

// ----- tb/sv/resp_command_framer_core_tb.sv -----
`timescale 1ns / 1ps

module resp_command_framer_core_tb;
   import rcf_pkg::*;

   localparam int STAGES          = 5;
   localparam int ITEMS_PER_STAGE = 100;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [BYTE_W-1:0]      FLUSH_BYTE    = 8'h78;
   localparam logic [LENGTH_BITS-1:0] LEN_ALL_ONES  = '1;
   localparam logic [LENGTH_BITS-1:0] COUNT_CEILING =
      LENGTH_BITS'((64'd1 << COUNT_BITS) - 64'd1);

   typedef struct {
      kind_type               kind;
      logic [BYTE_W-1:0]      data;
      logic [ARG_INDEX_W-1:0] index;
      logic                   done;
      error_type              code;
   } framer_result_type;

   // Block ports.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_byte_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KIND_W-1:0]      rsp_result_kind;
   logic [BYTE_W-1:0]      rsp_data_byte;
   logic [ARG_INDEX_W-1:0] rsp_arg_index;
   logic                   rsp_command_done;
   logic [ERROR_W-1:0]     rsp_error_code;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Stimulus, flow control and bookkeeping.
   logic [BYTE_W-1:0] stream_bytes[$];
   framer_result_type awaited_results[$];
   int unsigned       stage_items = 0;
   int unsigned       send_idle_pct = 15;
   int unsigned       recv_idle_pct = 69;
   logic              req_taken = 1'b0;
   logic              hold_trigger = 1'b0;
   logic              hold_seen = 1'b0;
   int unsigned       hold_left = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       mismatches = 0;
   int unsigned       bytes_accepted = 0;
   int unsigned       results_checked = 0;
   int unsigned       data_seen = 0;
   int unsigned       ends_seen = 0;
   int unsigned       commands_seen = 0;
   int unsigned       faults_seen = 0;

   // Our own copy of the parser state and of its limits.
   phase_type              fr_phase = PH_IDLE;
   logic [COUNT_BITS-1:0]  args_wanted = '0;
   logic [COUNT_BITS-1:0]  args_done = '0;
   logic [LENGTH_BITS-1:0] bytes_owed = '0;
   logic [LENGTH_BITS-1:0] number_acc = '0;
   logic                   got_digit = 1'b0;
   logic [MAX_ARGS_W-1:0]  limit_args = MAX_ARGS_RESET;
   logic [MAX_BULK_W-1:0]  limit_bulk = MAX_BULK_LEN_RESET;

   resp_command_framer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_arg_index    (rsp_arg_index),
      .rsp_command_done (rsp_command_done),
      .rsp_error_code   (rsp_error_code),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advances the parser by one byte; returns 1 when the byte yields a result.
   function automatic bit parse_byte(input logic [BYTE_W-1:0] b,
                                     output framer_result_type r);
      logic [63:0]           acc;
      logic [COUNT_BITS-1:0] next_done;
      error_type             fault;
      fault   = ERR_NONE;
      r.kind  = KIND_DATA;
      r.data  = '0;
      r.index = '0;
      r.done  = 1'b0;
      r.code  = ERR_NONE;
      parse_byte = 1'b0;
      case (fr_phase)
         PH_IDLE: begin
            if (b == CHAR_STAR) begin
               number_acc = '0;
               got_digit  = 1'b0;
               fr_phase   = PH_CNT_NUM;
            end
         end
         PH_CNT_NUM, PH_LEN_NUM: begin
            // Digits accumulate and saturate; a CR closes the number.
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               acc = number_acc * 64'd10 + (b - CHAR_ZERO);
               number_acc = (acc > LEN_ALL_ONES) ? LEN_ALL_ONES : acc[LENGTH_BITS-1:0];
               got_digit  = 1'b1;
            end else if (b != CHAR_CR) begin
               fault = ERR_BAD_CHAR;
            end else begin
               fr_phase = (fr_phase == PH_CNT_NUM) ? PH_CNT_LF : PH_LEN_LF;
            end
         end
         PH_CNT_LF: begin
            if (b != CHAR_LF || !got_digit) begin
               fault = ERR_BAD_CHAR;
            end else if (number_acc == 0 || number_acc > COUNT_CEILING ||
                         number_acc > limit_args) begin
               fault = ERR_BAD_COUNT;
            end else begin
               args_wanted = number_acc[COUNT_BITS-1:0];
               args_done   = '0;
               fr_phase    = PH_DOLLAR;
            end
         end
         PH_DOLLAR: begin
            if (b != CHAR_DOLLAR) begin
               fault = ERR_BAD_CHAR;
            end else begin
               number_acc = '0;
               got_digit  = 1'b0;
               fr_phase   = PH_LEN_NUM;
            end
         end
         PH_LEN_LF: begin
            if (b != CHAR_LF || !got_digit) begin
               fault = ERR_BAD_CHAR;
            end else if (number_acc == LEN_ALL_ONES || number_acc > limit_bulk) begin
               fault = ERR_TOO_LONG;
            end else if (number_acc == 0) begin
               bytes_owed = TRAIL_BYTES;
               fr_phase   = PH_TRAIL;
            end else begin
               bytes_owed = number_acc;
               fr_phase   = PH_DATA;
            end
         end
         PH_DATA: begin
            bytes_owed = bytes_owed - 1'b1;
            if (bytes_owed == 0) begin
               bytes_owed = TRAIL_BYTES;
               fr_phase   = PH_TRAIL;
            end
            r.data     = b;
            r.index    = args_done;
            parse_byte = 1'b1;
         end
         default: begin
            // The trailer is skipped unchecked; its second byte ends the argument.
            bytes_owed = bytes_owed - 1'b1;
            if (bytes_owed == 0) begin
               next_done  = args_done + 1'b1;
               r.kind     = KIND_ARG_END;
               r.index    = args_done;
               r.done     = (next_done == args_wanted);
               args_done  = next_done;
               fr_phase   = r.done ? PH_IDLE : PH_DOLLAR;
               parse_byte = 1'b1;
            end
         end
      endcase
      if (fault != ERR_NONE) begin
         r.kind     = KIND_ERROR;
         r.code     = fault;
         fr_phase   = PH_IDLE;
         parse_byte = 1'b1;
      end
   endfunction

   // Stimulus builders.
   task automatic put_byte(input logic [BYTE_W-1:0] b);
      stream_bytes.insert(stream_bytes.size(), b);
      stage_items++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_crlf();
      put_byte(CHAR_CR);
      put_byte(CHAR_LF);
   endtask

   // Decimal number, now and then with a leading zero.
   task automatic put_number(input longint unsigned n);
      if ($urandom_range(3) == 0) put_byte(CHAR_ZERO);
      put_text($sformatf("%0d", n));
   endtask

   function automatic logic [BYTE_W-1:0] byte_outside(input logic [BYTE_W-1:0] lo, hi, other);
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(255));
      while ((b >= lo && b <= hi) || b == other) b = BYTE_W'($urandom_range(255));
      return b;
   endfunction

   // A command with random content that fits the current limits; its trailers are now and then random bytes.
   task automatic put_frame();
      int unsigned arg_total;
      int unsigned len;
      int unsigned top;
      arg_total = $urandom_range((limit_args < 4) ? limit_args : 4, 1);
      put_byte(CHAR_STAR);
      put_number(arg_total);
      put_crlf();
      for (int i = 0; i < arg_total; i++) begin
         top = ($urandom_range(9) == 0) ? 24 : 6;
         if (limit_bulk < top) top = limit_bulk;
         len = $urandom_range(top, 0);
         put_byte(CHAR_DOLLAR);
         put_number(len);
         put_crlf();
         for (int k = 0; k < len; k++) put_byte(BYTE_W'($urandom_range(255)));
         if ($urandom_range(4) == 0) begin
            put_byte(BYTE_W'($urandom_range(255)));
            put_byte(BYTE_W'($urandom_range(255)));
         end else begin
            put_crlf();
         end
      end
   endtask

   // A command that breaks off with an error somewhere in its headers.
   task automatic put_broken();
      int unsigned pick;
      pick = $urandom_range(7);
      put_byte(CHAR_STAR);
      case (pick)
         0: begin
            if ($urandom_range(1)) put_number($urandom_range(9));
            put_byte(byte_outside(CHAR_ZERO, CHAR_NINE, CHAR_CR));
         end
         1: begin
            put_number($urandom_range(3, 1));
            put_byte(CHAR_CR);
            put_byte(byte_outside(CHAR_LF, CHAR_LF, CHAR_LF));
         end
         2: put_crlf();
         3: begin
            if ($urandom_range(1)) put_text("0");
            else put_text("000");
            put_crlf();
         end
         4: begin
            if ($urandom_range(3) == 0) put_text("99999999999");
            else put_number(longint'(limit_args) + $urandom_range(100, 1));
            put_crlf();
         end
         5: begin
            put_text("1");
            put_crlf();
            put_byte(byte_outside(CHAR_DOLLAR, CHAR_DOLLAR, CHAR_DOLLAR));
         end
         6: begin
            put_text("1");
            put_crlf();
            put_byte(CHAR_DOLLAR);
            case ($urandom_range(2))
               0: put_text("99999999999");
               1: put_text("1073741823");
               default: put_number(longint'(limit_bulk) + $urandom_range(1000, 1));
            endcase
            put_crlf();
         end
         default: begin
            put_text("1");
            put_crlf();
            put_byte(CHAR_DOLLAR);
            case ($urandom_range(2))
               0: put_crlf();
               1: begin
                  put_number($urandom_range(5));
                  put_byte(byte_outside(CHAR_ZERO, CHAR_NINE, CHAR_CR));
               end
               default: begin
                  put_number($urandom_range(5));
                  put_byte(CHAR_CR);
                  put_byte(byte_outside(CHAR_LF, CHAR_LF, CHAR_LF));
               end
            endcase
         end
      endcase
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MAX_ARGS) limit_args = value[MAX_ARGS_W-1:0];
      else limit_bulk = value[MAX_BULK_W-1:0];
   endtask

   // Waits until every item is taken and every result checked, then lets the pipe empty.
   task automatic settle();
      while (stream_bytes.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: offers the next pending item once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid      <= 1'b1;
            req_byte_value <= stream_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: predicts on every accepted input item and checks every accepted result.
   always @(posedge clock) begin : monitor
      framer_result_type want;
      bit                produced;
      if ((req_valid && !req_stall && !reset) || (rsp_valid && !rsp_stall && !reset))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            bytes_accepted++;
            produced = parse_byte(req_byte_value, want);
            if (produced) awaited_results.insert(awaited_results.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result kind %0d data %02h arg %0d done %0b err %0d",
                           $realtime, rsp_result_kind, rsp_data_byte, rsp_arg_index,
                           rsp_command_done, rsp_error_code);
            end else begin
               want = awaited_results.pop_front();
               results_checked++;
               case (want.kind)
                  KIND_DATA:    data_seen++;
                  KIND_ARG_END: ends_seen++;
                  default:      faults_seen++;
               endcase
               if (want.done) commands_seen++;
               if (rsp_result_kind !== want.kind || rsp_data_byte !== want.data ||
                   rsp_arg_index !== want.index || rsp_command_done !== want.done ||
                   rsp_error_code !== want.code) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: result %0d expected kind %0d data %02h arg %0d done %0b err %0d",
                              $realtime, results_checked, want.kind, want.data, want.index,
                              want.done, want.code);
                     $display("   got kind %0d data %02h arg %0d done %0b err %0d",
                              rsp_result_kind, rsp_data_byte, rsp_arg_index,
                              rsp_command_done, rsp_error_code);
                  end
               end
            end
         end
      end
   end

   // Watchdog: ends the run if nothing moves on either channel for too long.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("resp_command_framer_core_tb: done, errors");
      $finish;
   end

   // Test sequence: one stage per register setting.
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int stage = 0; stage < STAGES; stage++) begin
         case (stage)
            1: begin
               write_register(CSR_MAX_ARGS, CSR_DATA_W'(1));
               write_register(CSR_MAX_BULK_LEN, CSR_DATA_W'(0));
            end
            2: begin
               write_register(CSR_MAX_ARGS, CSR_DATA_W'(65535));
               write_register(CSR_MAX_BULK_LEN, CSR_DATA_W'(536870912));
            end
            3: begin
               write_register(CSR_MAX_ARGS, CSR_DATA_W'(3));
               write_register(CSR_MAX_BULK_LEN, CSR_DATA_W'(5));
            end
            4: begin
               write_register(CSR_MAX_ARGS, CSR_DATA_W'($urandom_range(8, 2)));
               write_register(CSR_MAX_BULK_LEN, CSR_DATA_W'($urandom_range(40, 4)));
            end
            default: ;
         endcase

         // Sender idles lightly first, then the receiver, then neither.
         if (stage < 2) begin
            send_idle_pct = 15;
            recv_idle_pct = 69;
         end else if (stage < 4) begin
            send_idle_pct = 69;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_trigger  = ~hold_trigger;
         end

         stage_items = 0;
         if (stage == 0) begin
            // Noise outside a frame, extreme data bytes, an empty last argument
            // with an unchecked trailer, a zero count and a stray count character.
            put_byte(8'h41);
            put_text("*2\r\n$2\r\n");
            put_byte(8'h00);
            put_byte(8'hFF);
            put_text("\r\n$0\r\nxy");
            put_text("*0\r\n");
            put_text("*1x");
         end

         while (stage_items < ITEMS_PER_STAGE) begin
            case ($urandom_range(99) / 5)
               0, 1, 2: put_broken();
               3, 4, 5: repeat ($urandom_range(4, 1)) put_byte(BYTE_W'($urandom_range(255)));
               default: put_frame();
            endcase
         end

         settle();
         // Bring the parser back to idle before the next register write.
         while (fr_phase != PH_IDLE) begin
            put_byte(FLUSH_BYTE);
            settle();
         end
      end

      $display("Covered %0d bytes over %0d limit settings, three idling mixes and a hold-off.",
               bytes_accepted, STAGES);
      $display("Checked %0d results: %0d data, %0d arg ends, %0d commands, %0d errors.",
               results_checked, data_seen, ends_seen, commands_seen, faults_seen);
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("resp_command_framer_core_tb: done, clean");
      else
         $display("resp_command_framer_core_tb: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/rcf_pkg.sv
hdl/resp_command_framer_core.sv
tb/sv/resp_command_framer_core_tb.sv
